@@ design/fbpa_pkg.sv @@
package fbpa_pkg;

    localparam int MAX_CACHE = 8;
    localparam int SLOTS     = MAX_CACHE + 1;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 4;
    localparam int ID_W      = 16;

    localparam logic [ID_W-1:0] ID_NONE = '1;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_GET  = 2'd1,
        ACT_PUT  = 2'd2,
        ACT_SET  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        US_FREE = 2'd0,
        US_CUR  = 2'd1,
        US_PREP = 2'd2
    } use_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_en;
        logic commit;
        logic addr_scan;
    } ctrl_t;

    typedef struct packed {
        logic req_is_get;
        logic idx_zero;
    } stat_t;

endpackage

@@ design/fbpa_req_if.sv @@
interface fbpa_req_if import fbpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [ID_W-1:0]   request_id;
    logic                     for_current;
    logic [SLOT_W-1:0]        slot;
    logic                     picture_filled;

    modport source (
        output valid, action, request_id, for_current, slot, picture_filled,
        input  ready
    );
    modport sink (
        input  valid, action, request_id, for_current, slot, picture_filled,
        output ready
    );
endinterface

@@ design/fbpa_rsp_if.sv @@
interface fbpa_rsp_if import fbpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [SLOT_W-1:0] granted_slot;
    logic              is_device_buffer;
    logic              holds_picture;

    modport source (
        output valid, granted, granted_slot, is_device_buffer, holds_picture,
        input  ready
    );
    modport sink (
        input  valid, granted, granted_slot, is_device_buffer, holds_picture,
        output ready
    );
endinterface

@@ design/fbpa_ctrl.sv @@
module fbpa_ctrl import fbpa_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.req_is_get ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (stat.idx_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.load_item = in_valid;
            end
            ST_SCAN:
            begin
                ctrl.scan_en   = 1'b1;
                ctrl.addr_scan = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.commit = !out_valid_reg || out_ready;
            end
            default: ctrl = '0;
        endcase
    end

    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/fbpa_dp.sv @@
module fbpa_dp import fbpa_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata,
    input  logic [1:0]             in_action,
    input  logic signed [ID_W-1:0] in_request_id,
    input  logic                   in_for_current,
    input  logic [SLOT_W-1:0]      in_slot,
    input  logic                   in_picture_filled,
    input  ctrl_t                  ctrl,
    output stat_t                  stat,
    output logic                   granted,
    output logic [SLOT_W-1:0]      granted_slot,
    output logic                   is_device_buffer,
    output logic                   holds_picture
);

    // configuration and pool size
    logic [CNT_W-1:0]  cfg_reg;
    logic [SLOT_W-1:0] count_reg, count_next;

    // slot state
    use_t              use_reg   [SLOTS];
    use_t              use_next  [SLOTS];
    logic [ID_W-1:0]   owner_reg [SLOTS];
    logic [ID_W-1:0]   owner_next[SLOTS];
    logic              pic_reg   [SLOTS];
    logic              pic_next  [SLOTS];

    // latched item
    action_t           act_reg;
    logic [ID_W-1:0]   id_reg;
    logic              cur_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              fill_reg;

    // scan state: first hit of each pass
    logic [SLOT_W-1:0] idx_reg;
    logic              h0v_reg, h1v_reg, h2v_reg;
    logic [SLOT_W-1:0] h0_reg, h1_reg, h2_reg;

    // result payload
    logic              granted_reg, dev_reg, holds_reg;
    logic [SLOT_W-1:0] gslot_reg;

    logic [SLOT_W-1:0] addr;
    logic              addr_ok;
    use_t              rd_use;
    logic [ID_W-1:0]   rd_owner;
    logic              rd_pic;
    logic              slot_free;

    logic [SLOT_W-1:0] sat_count;
    logic              found_v;
    logic [SLOT_W-1:0] found_slot;
    logic              keep_pic;
    logic              slot_in_pool;

    logic              res_granted;
    logic [SLOT_W-1:0] res_slot;
    logic              res_holds;

    assign sat_count = (cfg_reg > CNT_W'(MAX_CACHE)) ? SLOT_W'(MAX_CACHE) : SLOT_W'(cfg_reg);

    // get resolution: matching id, then blank, then any free, then forced
    always_comb
    begin
        found_v    = h0v_reg || h1v_reg || h2v_reg || cur_reg;
        keep_pic   = h0v_reg || h1v_reg;
        if (h0v_reg)
        begin
            found_slot = h0_reg;
        end
        else if (h1v_reg)
        begin
            found_slot = h1_reg;
        end
        else if (h2v_reg)
        begin
            found_slot = h2_reg;
        end
        else
        begin
            found_slot = count_reg;
        end
    end

    assign slot_in_pool = (slot_reg <= count_reg);

    // single read port
    always_comb
    begin
        if (ctrl.addr_scan)
        begin
            addr = idx_reg;
        end
        else if (act_reg == ACT_GET)
        begin
            addr = found_slot;
        end
        else
        begin
            addr = slot_reg;
        end
    end

    assign addr_ok   = (addr <= SLOT_W'(MAX_CACHE));
    assign rd_use    = addr_ok ? use_reg[addr]   : US_FREE;
    assign rd_owner  = addr_ok ? owner_reg[addr] : '0;
    assign rd_pic    = addr_ok ? pic_reg[addr]   : 1'b0;
    assign slot_free = (rd_use == US_FREE);

    assign stat.req_is_get = (action_t'(in_action) == ACT_GET);
    assign stat.idx_zero   = (idx_reg == '0);

    // result and state update for the item
    always_comb
    begin
        count_next  = count_reg;
        use_next    = use_reg;
        owner_next  = owner_reg;
        pic_next    = pic_reg;
        res_granted = 1'b0;
        res_slot    = slot_reg;
        res_holds   = 1'b0;
        case (act_reg)
            ACT_INIT:
            begin
                count_next  = sat_count;
                for (int i = 0; i < SLOTS; i++)
                begin
                    use_next[i]   = US_FREE;
                    owner_next[i] = '0;
                    pic_next[i]   = 1'b0;
                end
                if (sat_count != '0)
                begin
                    use_next[0] = US_CUR;
                end
                res_granted = 1'b1;
            end
            ACT_GET:
            begin
                if (found_v)
                begin
                    use_next[found_slot] = cur_reg ? US_CUR : US_PREP;
                    if (!h0v_reg)
                    begin
                        owner_next[found_slot] = id_reg;
                    end
                    if (!keep_pic)
                    begin
                        pic_next[found_slot] = 1'b0;
                    end
                    res_granted = 1'b1;
                    res_slot    = found_slot;
                    res_holds   = keep_pic && rd_pic;
                end
            end
            ACT_PUT:
            begin
                if (slot_in_pool)
                begin
                    use_next[slot_reg] = US_FREE;
                    if (rd_owner == ID_NONE)
                    begin
                        pic_next[slot_reg] = 1'b0;
                    end
                    res_granted = 1'b1;
                    res_holds   = (rd_owner != ID_NONE) && rd_pic;
                end
            end
            ACT_SET:
            begin
                if (slot_in_pool)
                begin
                    pic_next[slot_reg] = fill_reg;
                    res_granted        = 1'b1;
                    res_holds          = fill_reg;
                end
            end
            default: res_granted = 1'b0;
        endcase
    end

    // configuration, pool size and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            count_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                use_reg[i]   <= US_FREE;
                owner_reg[i] <= '0;
                pic_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (ctrl.commit)
            begin
                count_reg <= count_next;
                use_reg   <= use_next;
                owner_reg <= owner_next;
                pic_reg   <= pic_next;
            end
        end
    end

    // scan progress and first hits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            h0v_reg <= 1'b0;
            h1v_reg <= 1'b0;
            h2v_reg <= 1'b0;
        end
        else if (ctrl.load_item)
        begin
            idx_reg <= count_reg;
            h0v_reg <= 1'b0;
            h1v_reg <= 1'b0;
            h2v_reg <= 1'b0;
        end
        else if (ctrl.scan_en)
        begin
            idx_reg <= idx_reg - SLOT_W'(1);
            if (slot_free && !h0v_reg && (rd_owner == id_reg))
            begin
                h0v_reg <= 1'b1;
            end
            if (slot_free && !h1v_reg && !rd_pic)
            begin
                h1v_reg <= 1'b1;
            end
            if (slot_free && !h2v_reg)
            begin
                h2v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_en)
        begin
            if (slot_free && !h0v_reg && (rd_owner == id_reg))
            begin
                h0_reg <= idx_reg;
            end
            if (slot_free && !h1v_reg && !rd_pic)
            begin
                h1_reg <= idx_reg;
            end
            if (slot_free && !h2v_reg)
            begin
                h2_reg <= idx_reg;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            act_reg  <= action_t'(in_action);
            id_reg   <= $unsigned(in_request_id);
            cur_reg  <= in_for_current;
            slot_reg <= in_slot;
            fill_reg <= in_picture_filled;
        end
        if (ctrl.commit)
        begin
            granted_reg <= res_granted;
            gslot_reg   <= res_slot;
            dev_reg     <= res_granted && (res_slot == '0);
            holds_reg   <= res_holds;
        end
    end

    assign granted          = granted_reg;
    assign granted_slot     = gslot_reg;
    assign is_device_buffer = dev_reg;
    assign holds_picture    = holds_reg;

endmodule

@@ design/frame_buffer_pool_allocator.sv @@
// Display buffer pool allocator. Slot 0 is the device frame buffer, slots 1..N
// are cache buffers, N taken from cache_buffers (saturated to 8) at each init.
// One item is handled at a time. Init, put and set go from idle straight to the
// commit state, which loads the result register. A get first scans the pool
// one slot per cycle from slot N down to 0 and evaluates all three search passes
// in the same sweep, then commits. A result still waiting on rsp holds the
// commit state, and so that load, until rsp takes it. The result register parts
// the two channels, so a new item may be accepted while the previous result
// still waits on rsp. cache_buffers is written through cfg_we/cfg_wdata and
// only takes effect on the next init.
module frame_buffer_pool_allocator import fbpa_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    fbpa_req_if.sink         req,
    fbpa_rsp_if.source       rsp
);

    ctrl_t ctrl;
    stat_t stat;

    // sequencer: idle, slot scan for get, commit into result register
    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // slot tables, scan hits and result payload
    fbpa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_action         (req.action),
        .in_request_id     (req.request_id),
        .in_for_current    (req.for_current),
        .in_slot           (req.slot),
        .in_picture_filled (req.picture_filled),
        .ctrl              (ctrl),
        .stat              (stat),
        .granted           (rsp.granted),
        .granted_slot      (rsp.granted_slot),
        .is_device_buffer  (rsp.is_device_buffer),
        .holds_picture     (rsp.holds_picture)
    );

    // device flag only ever comes with a grant of slot 0
    a_dev_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_device_buffer |-> rsp.granted && (rsp.granted_slot == '0))
        else $error("device flag without grant of slot 0");

    // a picture is only reported for a granted slot inside the table
    a_pic_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.holds_picture |->
            rsp.granted && (rsp.granted_slot <= SLOT_W'(MAX_CACHE)))
        else $error("picture flag outside pool");

    // a commit never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> !rsp.valid || rsp.ready)
        else $error("result overwritten");

    // no new item while a scan is running
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.scan_en |-> !ctrl.load_item && !req.ready)
        else $error("item accepted during scan");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fbpa_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 300;
    localparam int MAX_REPORTS = 10;

    // one result item as seen on the response channel
    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic              device;
        logic              picture;
    } grant_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    fbpa_req_if req_if ();
    fbpa_rsp_if rsp_if ();

    frame_buffer_pool_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if.sink),
        .rsp       (rsp_if.source)
    );

    // shadow of the pool: register, active size and per-slot bookkeeping
    logic [CNT_W-1:0] cache_reg;
    logic [CNT_W-1:0] pool_size;
    use_t             use_q   [SLOTS];
    logic [ID_W-1:0]  owner_q [SLOTS];
    logic             pic_q   [SLOTS];

    // grants still owed by the block, oldest first
    grant_t pending_grants[$];

    int  mismatches;
    int  cycles;
    bit  calm;
    int  n_items;
    int  n_refused;
    int  n_forced;
    int  n_outside;
    int  act_count[4];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // pool state right after reset: only the free device slot
    function automatic void clear_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            use_q[i]   = US_FREE;
            owner_q[i] = '0;
            pic_q[i]   = 1'b0;
        end
    endfunction

    // works out the grant for one accepted item and updates the shadow pool
    function automatic grant_t allocate(input action_t act, input logic [ID_W-1:0] id,
                                        input logic cur, input logic [SLOT_W-1:0] slot,
                                        input logic filled);
        grant_t g;
        int     found;
        int     hit_pass;
        logic   in_pool;
        g.granted = 1'b0;
        g.slot    = slot;
        found     = -1;
        hit_pass  = -1;
        case (act)
            ACT_INIT:
            begin
                // oversized register values saturate to the largest pool
                pool_size = (cache_reg > MAX_CACHE) ? CNT_W'(MAX_CACHE) : cache_reg;
                clear_pool();
                if (pool_size != 0)
                    use_q[0] = US_CUR;
                g.granted = 1'b1;
            end
            ACT_GET:
            begin
                // same id first, then a blank slot, then any free slot;
                // every pass scans from the top slot down
                for (int pass = 0; pass < 3 && found < 0; pass++)
                begin
                    for (int i = int'(pool_size); i >= 0 && found < 0; i--)
                    begin
                        if (use_q[i] == US_FREE &&
                            !(pass == 0 && owner_q[i] != id) &&
                            !(pass == 1 && pic_q[i]))
                        begin
                            found    = i;
                            hit_pass = pass;
                        end
                    end
                end
                if (found >= 0)
                begin
                    if (hit_pass >= 1)
                        owner_q[found] = id;
                    if (hit_pass == 2)
                        pic_q[found] = 1'b0;
                end
                else if (cur)
                begin
                    // pool exhausted but the frame needs a buffer now
                    found          = int'(pool_size);
                    owner_q[found] = id;
                    pic_q[found]   = 1'b0;
                    n_forced++;
                end
                else
                    n_refused++;
                if (found >= 0)
                begin
                    use_q[found] = cur ? US_CUR : US_PREP;
                    g.granted    = 1'b1;
                    g.slot       = SLOT_W'(found);
                end
            end
            default:
            begin
                if (slot <= pool_size)
                begin
                    if (act == ACT_PUT)
                    begin
                        use_q[slot] = US_FREE;
                        if (owner_q[slot] == ID_NONE)
                            pic_q[slot] = 1'b0;
                    end
                    else
                        pic_q[slot] = filled;
                    g.granted = 1'b1;
                end
                else
                    n_outside++;
            end
        endcase
        in_pool   = (act == ACT_GET) ? g.granted : (g.slot <= pool_size);
        g.device  = in_pool && (g.slot == 0);
        g.picture = in_pool ? pic_q[g.slot] : 1'b0;
        return g;
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a slot currently handed out, or -1 when every slot is free
    function automatic int pick_busy_slot();
        int busy[$];
        for (int i = 0; i <= int'(pool_size); i++)
            if (use_q[i] != US_FREE)
                busy.push_back(i);
        if (busy.size() == 0)
            return -1;
        return busy[$urandom_range(0, busy.size() - 1)];
    endfunction

    // drive one request item, hold it until accepted, then record the grant owed
    task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                             input logic cur, input logic [SLOT_W-1:0] slot,
                             input logic filled);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.action         <= act;
        req_if.request_id     <= id;
        req_if.for_current    <= cur;
        req_if.slot           <= slot;
        req_if.picture_filled <= filled;
        do
            @(posedge clk);
        while (!req_if.ready);
        // valid stays high here; the next item or settle() decides what follows
        pending_grants.push_back(allocate(act, id, cur, slot, filled));
        act_count[int'(act)]++;
        n_items++;
    endtask

    // drop valid and wait until the block has delivered everything
    task automatic settle();
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cache_count(input logic [CNT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cache_reg  = value;
    endtask

    // pool as left by reset: lone device slot, free and not yet in use
    task automatic test_reset_pool();
        send_item(ACT_GET, 16'd5, 1'b0, 4'd0, 1'b0);
        send_item(ACT_GET, 16'd6, 1'b0, 4'd0, 1'b0);     // nothing free, refused
        send_item(ACT_GET, ID_NONE, 1'b1, 4'd3, 1'b0);   // nothing free, forced
        send_item(ACT_SET, 16'd0, 1'b0, 4'd0, 1'b1);
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd0, 1'b0);     // id is none, so blanked
        send_item(ACT_SET, 16'd0, 1'b0, 4'd9, 1'b1);     // outside the pool
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd15, 1'b0);    // outside the pool
    endtask

    // two cache buffers: walk through all three search passes and exhaustion
    task automatic test_search_passes();
        write_cache_count(4'd2);
        send_item(ACT_INIT, 16'd0, 1'b0, 4'd0, 1'b0);
        send_item(ACT_GET, 16'h8000, 1'b0, 4'd0, 1'b0);  // blank slot 2
        send_item(ACT_SET, 16'd0, 1'b0, 4'd2, 1'b1);
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd2, 1'b0);     // keeps its picture
        send_item(ACT_GET, 16'h8000, 1'b1, 4'd0, 1'b0);  // same id, filled
        send_item(ACT_SET, 16'd0, 1'b0, 4'd1, 1'b1);
        send_item(ACT_GET, 16'h7fff, 1'b0, 4'd0, 1'b0);  // only a filled slot left
        send_item(ACT_GET, 16'h1234, 1'b0, 4'd0, 1'b0);  // refused
        send_item(ACT_GET, 16'h1234, 1'b1, 4'd0, 1'b0);  // forced onto slot 2
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd0, 1'b0);     // release the device slot
    endtask

    // register above the largest pool saturates at init
    task automatic test_oversized_count();
        write_cache_count(4'd15);
        send_item(ACT_INIT, 16'd0, 1'b0, 4'd0, 1'b0);
        send_item(ACT_GET, ID_NONE, 1'b1, 4'd0, 1'b0);   // top slot 8
        send_item(ACT_SET, 16'd0, 1'b0, 4'd8, 1'b1);
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd8, 1'b0);     // blanked, id is none
        send_item(ACT_SET, 16'd0, 1'b0, 4'd12, 1'b1);
        send_item(ACT_PUT, 16'd0, 1'b0, 4'd9, 1'b0);
    endtask

    // one random item, biased toward ids and slots that the pool knows about
    task automatic send_random_item();
        int               r;
        int               busy;
        action_t          act;
        logic [ID_W-1:0]  id;
        logic [SLOT_W-1:0] slot;
        r = $urandom_range(0, 99);
        if (r < 3)
            act = ACT_INIT;
        else if (r < 50)
            act = ACT_GET;
        else if (r < 80)
            act = ACT_PUT;
        else
            act = ACT_SET;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            case ($urandom_range(0, 4))
                0:       id = '0;
                1:       id = ID_NONE;
                default: id = ID_W'($urandom_range(1, 3));
            endcase
        end
        else if (r < 70)
            id = owner_q[$urandom_range(0, int'(pool_size))];
        else
            id = ID_W'($urandom);
        r    = $urandom_range(0, 99);
        busy = pick_busy_slot();
        if (r < 60 && busy >= 0)
            slot = SLOT_W'(busy);
        else if (r < 90)
            slot = SLOT_W'($urandom_range(0, int'(pool_size)));
        else
            slot = SLOT_W'($urandom_range(0, 15));
        send_item(act, id, 1'($urandom_range(0, 1)), slot, 1'($urandom_range(0, 1)));
    endtask

    // one configuration setting: rebuild the pool and run random traffic on it
    task automatic test_random_phase(input logic [CNT_W-1:0] count, input bit quiet);
        write_cache_count(count);
        calm = quiet;
        send_item(ACT_INIT, ID_W'($urandom), 1'b0, SLOT_W'($urandom_range(0, 15)), 1'b0);
        repeat (PHASE_ITEMS) send_random_item();
        settle();
        calm = 1'b0;
    endtask

    // response stalls, on the same gap pattern as the request side
    initial
    begin : rsp_stall
        int stall;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // compare every delivered item with the oldest grant owed
    always @(posedge clk)
    begin : check_grant
        grant_t want;
        grant_t seen;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            seen = {rsp_if.granted, rsp_if.granted_slot, rsp_if.is_device_buffer,
                    rsp_if.holds_picture};
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb_top: unexpected item %p at cycle %0d", seen, cycles);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (seen.granted !== want.granted || seen.slot !== want.slot ||
                    seen.device !== want.device || seen.picture !== want.picture)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb_top: mismatch at cycle %0d: expected %p, got %p",
                                 cycles, want, seen);
                end
            end
        end
    end

    initial
    begin
        cycles     = 0;
        mismatches = 0;
        calm       = 1'b0;
        cache_reg  = '0;
        pool_size  = '0;
        clear_pool();
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        req_if.valid          <= 1'b0;
        req_if.action         <= ACT_INIT;
        req_if.request_id     <= '0;
        req_if.for_current    <= 1'b0;
        req_if.slot           <= '0;
        req_if.picture_filled <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pool();
        test_search_passes();
        test_oversized_count();
        test_random_phase(4'd8, 1'b0);
        test_random_phase(4'd0, 1'b0);
        test_random_phase(4'd1, 1'b1);
        test_random_phase(4'd4, 1'b0);
        test_random_phase(4'd9, 1'b0);
        test_random_phase(CNT_W'($urandom_range(0, 15)), 1'b0);

        settle();
        repeat (20) @(posedge clk);
        mismatches += pending_grants.size();
        $display("tb_top: %0d items over pool sizes 0 to 8: %0d inits, %0d gets,",
                 n_items, act_count[0], act_count[1]);
        $display("tb_top: %0d puts, %0d sets, %0d gets refused, %0d forced on a full pool,",
                 act_count[2], act_count[3], n_refused, n_forced);
        $display("tb_top: %0d puts or sets on slots outside the pool", n_outside);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ frame_buffer_pool_allocator.f @@
design/fbpa_pkg.sv
design/fbpa_req_if.sv
design/fbpa_rsp_if.sv
design/fbpa_ctrl.sv
design/fbpa_dp.sv
design/frame_buffer_pool_allocator.sv
dv/tb_top.sv
